/* hdl/first_fit_block_allocator_top_defines.svh */
// Assertion macros shared by the allocator's checker.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FFBA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/ffba_pkg.sv */
// Types, codes and constants of the first-fit block allocator.
`default_nettype none
package ffba_pkg;

	localparam int MEM_WORDS_DEF = 1024;
	localparam int NUM_SLOTS_DEF = 10;
	localparam int RESET_SIZE    = 1024;
	localparam int MIN_SIZE      = 2;

	localparam int REQ_W  = 2;
	localparam int PID_W  = 4;
	localparam int AMT_W  = 11;
	localparam int STAT_W = 3;
	localparam int ADDR_W = 10;
	localparam int FREE_W = 11;
	localparam int DATA_W = 32;
	localparam int PADDR_W = 3;

	localparam logic [REQ_W-1:0] REQ_START = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LOC   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;
	// no action, answered with ok
	localparam logic [REQ_W-1:0] REQ_UNDEF = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_RUNNING  = 3'd1;
	localparam logic [STAT_W-1:0] ST_INACTIVE = 3'd2;
	localparam logic [STAT_W-1:0] ST_BOUNDS   = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOSPACE  = 3'd4;

	// register index of memory_size, taken from paddr[2]
	localparam logic REG_MEMSIZE = 1'b0;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [PID_W-1:0] process_id;
		logic [AMT_W-1:0] amount;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ADDR_W-1:0] address;
		logic [FREE_W-1:0] free_total;
	} rsp_t;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_DEC,
		S_T_SZ, S_T_LK, S_T_DEC, S_T_W1, S_T_W2, S_T_LINK, S_T_FAIL,
		S_G_CHK, S_G_NX, S_G_A, S_G_B, S_G_C, S_G_P, S_G_Q,
		S_G_M1, S_G_M2, S_G_S1, S_G_S2, S_G_S3, S_G_FIN,
		S_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CLR, OP_ACCEPT, OP_DECODE,
		OP_RD_CUR, OP_T_LK, OP_T_DEC, OP_T_W1, OP_T_W2, OP_T_LINK, OP_T_FAIL,
		OP_RD_CURLK, OP_G_STEP, OP_G_A, OP_G_B, OP_G_C, OP_RD_PREV, OP_G_Q,
		OP_G_M1, OP_G_M2, OP_G_S1, OP_G_S2, OP_G_S3, OP_G_FIN,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_alloc;
		logic is_free;
		logic cur_ok;
		logic fit;
		logic exact;
		logic walk_go;
		logic merge_next;
		logic prev_valid;
		logic merge_prev;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

/* hdl/ffba_ctrl.sv */
// Sequencer of the allocator: one state per step of a request, at most one memory access per state.
`default_nettype none
module ffba_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr,
	input  wire logic              req_valid,
	input  wire ffba_pkg::dp_stat_t stat,
	output ffba_pkg::dp_cmd_t      cmd,
	output logic                   req_stall
);
	import ffba_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd.op    = OP_NONE;
		unique case (state_q)
			S_CLR: begin
				cmd.op = OP_CLR;
				if (stat.clr_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.op    = OP_ACCEPT;
					state_nxt = S_DEC;
				end
			end
			S_DEC: begin
				if (stat.is_alloc) begin
					state_nxt = S_T_SZ;
				end else if (stat.is_free) begin
					state_nxt = S_G_CHK;
				end else begin
					cmd.op    = OP_DECODE;
					state_nxt = S_DONE;
				end
			end
			S_T_SZ: begin
				if (stat.cur_ok) begin
					cmd.op    = OP_RD_CUR;
					state_nxt = S_T_LK;
				end else begin
					state_nxt = S_T_FAIL;
				end
			end
			S_T_LK: begin
				cmd.op    = OP_T_LK;
				state_nxt = S_T_DEC;
			end
			S_T_DEC: begin
				cmd.op = OP_T_DEC;
				if (!stat.fit)      state_nxt = S_T_SZ;
				else if (stat.exact) state_nxt = S_T_LINK;
				else                state_nxt = S_T_W1;
			end
			S_T_W1: begin
				cmd.op    = OP_T_W1;
				state_nxt = S_T_W2;
			end
			S_T_W2: begin
				cmd.op    = OP_T_W2;
				state_nxt = S_T_LINK;
			end
			S_T_LINK: begin
				cmd.op    = OP_T_LINK;
				state_nxt = S_DONE;
			end
			S_T_FAIL: begin
				cmd.op    = OP_T_FAIL;
				state_nxt = S_DONE;
			end
			S_G_CHK: begin
				if (stat.walk_go) begin
					cmd.op    = OP_RD_CURLK;
					state_nxt = S_G_NX;
				end else begin
					state_nxt = S_G_A;
				end
			end
			S_G_NX: begin
				cmd.op    = OP_G_STEP;
				state_nxt = S_G_CHK;
			end
			S_G_A: begin
				cmd.op    = OP_G_A;
				state_nxt = stat.merge_next ? S_G_B : S_G_P;
			end
			S_G_B: begin
				cmd.op    = OP_G_B;
				state_nxt = S_G_C;
			end
			S_G_C: begin
				cmd.op    = OP_G_C;
				state_nxt = S_G_P;
			end
			S_G_P: begin
				cmd.op    = OP_RD_PREV;
				state_nxt = stat.prev_valid ? S_G_Q : S_G_S1;
			end
			S_G_Q: begin
				cmd.op    = OP_G_Q;
				state_nxt = stat.merge_prev ? S_G_M1 : S_G_S1;
			end
			S_G_M1: begin
				cmd.op    = OP_G_M1;
				state_nxt = S_G_M2;
			end
			S_G_M2: begin
				cmd.op    = OP_G_M2;
				state_nxt = S_G_FIN;
			end
			S_G_S1: begin
				cmd.op    = OP_G_S1;
				state_nxt = S_G_S2;
			end
			S_G_S2: begin
				cmd.op    = OP_G_S2;
				state_nxt = S_G_S3;
			end
			S_G_S3: begin
				cmd.op    = OP_G_S3;
				state_nxt = S_G_FIN;
			end
			S_G_FIN: begin
				cmd.op    = OP_G_FIN;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.op    = OP_EMIT;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
		// a register write restarts the clearing pass
		if (cfg_wr) begin
			cmd.op    = OP_NONE;
			state_nxt = S_CLR;
		end
	end

	assign req_stall = (state_q != S_IDLE);

endmodule
`default_nettype wire

/* hdl/ffba_dp.sv */
// Datapath of the allocator: block store, list pointers, slot table, result register.
`default_nettype none
module ffba_dp #(
	parameter int MEM_WORDS = ffba_pkg::MEM_WORDS_DEF,
	parameter int NUM_SLOTS = ffba_pkg::NUM_SLOTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr,
	input  wire logic [ffba_pkg::DATA_W-1:0]   cfg_data,
	input  wire ffba_pkg::req_t                req,
	input  wire ffba_pkg::dp_cmd_t             cmd,
	input  wire logic                          rsp_stall,
	output ffba_pkg::dp_stat_t                 stat,
	output ffba_pkg::rsp_t                     rsp,
	output logic                               rsp_valid,
	output logic [ffba_pkg::DATA_W-1:0]        mem_size
);
	import ffba_pkg::*;

	localparam int AW = $clog2(MEM_WORDS);
	localparam int VW = (AW + 1 > AMT_W) ? AW + 1 : AMT_W;
	localparam int EW = VW + 1;
	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int RST_SIZE = (RESET_SIZE > MEM_WORDS) ? MEM_WORDS : RESET_SIZE;
	localparam logic [VW-1:0] LIST_END = VW'(MEM_WORDS);

	logic [VW-1:0] mem_q [MEM_WORDS];
	logic [VW-1:0] rdata_q;
	logic          rd_end_q;

	req_t          req_q;
	logic [VW-1:0] cur_q, prev_q, csz_q, clink_q, nsize_q, nlink_q, psz_q;
	logic [EW-1:0] nxt_q, g_q;
	logic [VW-1:0] head_q, wfree_q, msize_q;
	logic [AW-1:0] clr_q;
	logic [STAT_W-1:0] res_status_q;
	logic [ADDR_W-1:0] res_addr_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	logic [AW-1:0]    sbase_q [NUM_SLOTS];
	logic [AMT_W-1:0] slen_q  [NUM_SLOTS];
	logic             sact_q  [NUM_SLOTS];

	logic [VW-1:0] rdata, size, wdata, clamp;
	logic [EW-1:0] raddr, waddr, s_base, loc_sum;
	logic          re, we, pid_ok, act;
	logic [SW-1:0] pidx;
	logic [AMT_W-1:0] len;
	logic [STAT_W-1:0] dec_status;
	logic [ADDR_W-1:0] dec_addr;

	// reads past the store give the end-of-list mark
	assign rdata  = rd_end_q ? LIST_END : rdata_q;
	assign size   = VW'(req_q.amount);
	assign pid_ok = (int'(req_q.process_id) < NUM_SLOTS);
	assign pidx   = SW'(req_q.process_id);
	assign act    = sact_q[pidx];
	assign len    = slen_q[pidx];
	assign s_base = EW'(sbase_q[pidx]);
	assign loc_sum = s_base + EW'(req_q.amount);

	always_comb begin
		if (cfg_data < DATA_W'(MIN_SIZE))       clamp = VW'(MIN_SIZE);
		else if (cfg_data > DATA_W'(MEM_WORDS)) clamp = VW'(MEM_WORDS);
		else                                    clamp = VW'(cfg_data);
	end

	// result of requests that need no list walk
	always_comb begin
		dec_status = ST_OK;
		dec_addr   = '0;
		if (!pid_ok && req_q.req_type != REQ_UNDEF) begin
			dec_status = ST_INACTIVE;
		end else if (req_q.req_type == REQ_START) begin
			dec_status = act ? ST_RUNNING : ST_OK;
		end else if (req_q.req_type == REQ_LOC) begin
			if (!act)                     dec_status = ST_INACTIVE;
			else if (req_q.amount >= len) dec_status = ST_BOUNDS;
			else                          dec_addr   = ADDR_W'(loc_sum);
		end else if (req_q.req_type == REQ_STOP) begin
			if (!act) dec_status = ST_INACTIVE;
			else      dec_addr   = ADDR_W'(s_base);
		end
	end

	// status toward the sequencer
	always_comb begin
		stat.clr_last   = (clr_q == AW'(MEM_WORDS - 1));
		stat.is_alloc   = pid_ok && (req_q.req_type == REQ_START) && (req_q.amount != '0);
		stat.is_free    = pid_ok && (req_q.req_type == REQ_STOP) && act && (len != '0);
		stat.cur_ok     = (cur_q < LIST_END) && (g_q <= EW'(MEM_WORDS));
		stat.fit        = (csz_q >= size);
		stat.exact      = (csz_q == size);
		stat.walk_go    = (cur_q < LIST_END) && (EW'(cur_q) < s_base)
		                  && (g_q <= EW'(MEM_WORDS));
		stat.merge_next = (cur_q < LIST_END) && (s_base + EW'(len) == EW'(cur_q));
		stat.prev_valid = (prev_q != LIST_END);
		stat.merge_prev = (EW'(prev_q) + EW'(rdata) == s_base);
		stat.out_free   = !rsp_valid_q || !rsp_stall;
	end

	// store port: one access per cycle, chosen by the command
	always_comb begin
		re = 1'b0; we = 1'b0;
		raddr = EW'(cur_q);
		waddr = EW'(cur_q);
		wdata = '0;
		unique case (cmd.op)
			OP_CLR: begin
				we    = 1'b1;
				waddr = EW'(clr_q);
				if (clr_q == AW'(0))      wdata = msize_q;
				else if (clr_q == AW'(1)) wdata = LIST_END;
				else                      wdata = '0;
			end
			OP_RD_CUR, OP_G_A: begin
				re = 1'b1; raddr = EW'(cur_q);
			end
			OP_T_LK, OP_RD_CURLK, OP_G_B: begin
				re = 1'b1; raddr = EW'(cur_q) + EW'(1);
			end
			OP_RD_PREV: begin
				re = 1'b1; raddr = EW'(prev_q);
			end
			OP_T_W1: begin
				we = 1'b1; waddr = nxt_q; wdata = csz_q - size;
			end
			OP_T_W2: begin
				we = 1'b1; waddr = nxt_q + EW'(1); wdata = clink_q;
			end
			OP_T_LINK: begin
				we = (prev_q != LIST_END); waddr = EW'(prev_q) + EW'(1);
				wdata = VW'(nxt_q);
			end
			OP_G_M1: begin
				we = 1'b1; waddr = EW'(prev_q); wdata = psz_q + nsize_q;
			end
			OP_G_M2: begin
				we = 1'b1; waddr = EW'(prev_q) + EW'(1); wdata = nlink_q;
			end
			OP_G_S1: begin
				we = 1'b1; waddr = s_base; wdata = nsize_q;
			end
			OP_G_S2: begin
				we = 1'b1; waddr = s_base + EW'(1); wdata = nlink_q;
			end
			OP_G_S3: begin
				we = (prev_q != LIST_END); waddr = EW'(prev_q) + EW'(1);
				wdata = VW'(s_base);
			end
			default: begin
				re = 1'b0; we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we && (waddr < EW'(MEM_WORDS))) mem_q[waddr[AW-1:0]] <= wdata;
		if (re) begin
			rd_end_q <= (raddr >= EW'(MEM_WORDS));
			rdata_q  <= mem_q[raddr[AW-1:0]];
		end
	end

	// list walk and request registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				req_q  <= req;
				cur_q  <= head_q;
				prev_q <= LIST_END;
				g_q    <= '0;
			end
			OP_T_LK: csz_q <= rdata;
			OP_T_DEC: begin
				clink_q <= rdata;
				nxt_q   <= (csz_q == size) ? EW'(rdata) : EW'(cur_q) + EW'(size);
				if (csz_q < size) begin
					prev_q <= cur_q;
					cur_q  <= rdata;
					g_q    <= g_q + EW'(1);
				end
			end
			OP_G_STEP: begin
				prev_q <= cur_q;
				cur_q  <= rdata;
				g_q    <= g_q + EW'(1);
			end
			OP_G_A: begin
				if (cur_q >= LIST_END) begin
					cur_q   <= LIST_END;
					nlink_q <= LIST_END;
				end else begin
					nlink_q <= cur_q;
				end
				nsize_q <= VW'(len);
			end
			OP_G_B: nsize_q <= nsize_q + rdata;
			OP_G_C: nlink_q <= rdata;
			OP_G_Q: psz_q   <= rdata;
			default: ;
		endcase
	end

	// free-list head, free count, slot table and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msize_q     <= VW'(RST_SIZE);
			head_q      <= '0;
			wfree_q     <= VW'(RST_SIZE);
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) sact_q[i] <= 1'b0;
		end else if (cfg_wr) begin
			msize_q <= clamp;
			head_q  <= '0;
			wfree_q <= clamp;
			clr_q   <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) sact_q[i] <= 1'b0;
		end else begin
			if (cmd.op == OP_EMIT)             rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;
			case (cmd.op)
				OP_CLR: clr_q <= clr_q + AW'(1);
				OP_DECODE: begin
					res_status_q <= dec_status;
					res_addr_q   <= dec_addr;
					if (pid_ok && req_q.req_type == REQ_START) begin
						sact_q[pidx]  <= 1'b1;
						sbase_q[pidx] <= '0;
						slen_q[pidx]  <= '0;
					end else if (pid_ok && req_q.req_type == REQ_STOP && act) begin
						sact_q[pidx] <= 1'b0;
					end
				end
				OP_T_LINK: begin
					if (prev_q == LIST_END) head_q <= VW'(nxt_q);
					wfree_q       <= (wfree_q >= size) ? wfree_q - size : '0;
					sact_q[pidx]  <= 1'b1;
					sbase_q[pidx] <= AW'(cur_q);
					slen_q[pidx]  <= req_q.amount;
					res_addr_q    <= ADDR_W'(cur_q);
					res_status_q  <= act ? ST_RUNNING : ST_OK;
				end
				OP_T_FAIL: begin
					res_status_q <= ST_NOSPACE;
					res_addr_q   <= '0;
				end
				OP_G_S3: if (prev_q == LIST_END) head_q <= VW'(s_base);
				OP_G_FIN: begin
					wfree_q      <= wfree_q + VW'(len);
					res_status_q <= ST_OK;
					res_addr_q   <= ADDR_W'(s_base);
					sact_q[pidx] <= 1'b0;
				end
				OP_EMIT: begin
					rsp_q.status     <= res_status_q;
					rsp_q.address    <= res_addr_q;
					rsp_q.free_total <= FREE_W'(wfree_q);
				end
				default: ;
			endcase
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;
	assign mem_size  = DATA_W'(msize_q);

endmodule
`default_nettype wire

/* hdl/first_fit_block_allocator_top.sv */
// Top level of the first-fit block allocator: APB register port, sequencer and datapath.
//
// Request channel (req_valid / req_stall / req): one word carries req_type (start,
// locate, stop), process_id and amount. A word is taken on a rising edge with
// req_valid high and req_stall low. One request is worked at a time.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one word per request,
// with status, address and the free word count after the request. The response
// sits in an output register, so a stalled response does not block the next
// request from being worked; the following response waits until it drains.
// Work per request, from accept to response valid:
//   locate, bad slot, inactive, zero-size start, empty stop : decode only, no list walk
//   start : walk of the free list, then link (exact fit) or split and link
//   start with no space : walk of the whole free list
//   stop  : walk to the returned base, then merge with or link to the neighbours
// The list walk is bound by the single-port block store: one read or write per
// cycle, read data registered.
// Reset and every write of memory_size run a clearing pass over the store, one
// word per cycle; req_stall is high during the pass.
// memory_size sits at byte address 0; writes are clamped to 2 .. MEM_WORDS and
// rebuild the whole state as one free block. Write it only while idle.
`default_nettype none
module first_fit_block_allocator_top #(
	parameter int MEM_WORDS = ffba_pkg::MEM_WORDS_DEF,
	parameter int NUM_SLOTS = ffba_pkg::NUM_SLOTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// register port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ffba_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [ffba_pkg::DATA_W-1:0]   pwdata,
	output logic      [ffba_pkg::DATA_W-1:0]   prdata,
	output logic                               pready,
	// request channel
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire ffba_pkg::req_t                req,
	// response channel
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output ffba_pkg::rsp_t                     rsp
);
	import ffba_pkg::*;

	dp_cmd_t             cmd;
	dp_stat_t            stat;
	logic                cfg_hit, cfg_wr;
	logic [DATA_W-1:0]   mem_size;

	// register decode: index is paddr[2], only memory_size exists
	assign pready  = 1'b1;
	assign cfg_hit = (paddr[2] == REG_MEMSIZE);
	assign cfg_wr  = psel && penable && pwrite && cfg_hit;
	assign prdata  = cfg_hit ? mem_size : '0;

	ffba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.req_valid (req_valid),
		.stat      (stat),
		.cmd       (cmd),
		.req_stall (req_stall)
	);

	ffba_dp #(
		.MEM_WORDS (MEM_WORDS),
		.NUM_SLOTS (NUM_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.cfg_data  (pwdata),
		.req       (req),
		.cmd       (cmd),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.mem_size  (mem_size)
	);

endmodule
`default_nettype wire

/* hdl/ffba_checker.sv */
// Port-level checks of the allocator, bound to the top level.
`default_nettype none
`include "first_fit_block_allocator_top_defines.svh"
module ffba_port_checker #(
	parameter int MEM_WORDS = ffba_pkg::MEM_WORDS_DEF
) (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_stall,
	input wire logic           rsp_valid,
	input wire logic           rsp_stall,
	input wire ffba_pkg::rsp_t rsp
);
	import ffba_pkg::*;

	// one request at a time: the port closes right after a word is taken
	`FFBA_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall, "request taken while busy")

	`FFBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")

	`FFBA_ASSERT_NOW(a_err_addr, rsp_valid && (rsp.status == ST_INACTIVE || rsp.status == ST_BOUNDS || rsp.status == ST_NOSPACE), rsp.address == '0, "error response with address")

	`FFBA_ASSERT_NOW(a_free_range, rsp_valid, rsp.free_total <= FREE_W'(MEM_WORDS), "free count above store size")

	`FFBA_ASSERT_NOW(a_status_code, rsp_valid, rsp.status <= ST_NOSPACE, "undefined status code")

endmodule

bind first_fit_block_allocator_top ffba_port_checker #(.MEM_WORDS(MEM_WORDS)) u_ffba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
`default_nettype wire
